>>> rtl/centered_window_trajectory_smoother_top_defines.svh
// assertion macros shared by the trajectory smoother rtl
`ifndef CENTERED_WINDOW_TRAJECTORY_SMOOTHER_TOP_DEFINES_SVH
`define CENTERED_WINDOW_TRAJECTORY_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication
`define CWTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CWTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cwts_pkg.sv
// types, constants and helpers of the trajectory smoother
package cwts_pkg;

    localparam int RADIUS     = 30;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 39;
    localparam int IDX_W      = 32;
    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HIST_W     = 3 * SAMPLE_W;
    localparam int CNT_W      = $clog2(2 * RADIUS + 1);
    localparam int STEP_W     = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pos_x;
        logic signed [SAMPLE_W-1:0] pos_y;
        logic signed [SAMPLE_W-1:0] angle;
        logic                       final_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smooth_x;
        logic signed [SAMPLE_W-1:0] smooth_y;
        logic signed [SAMPLE_W-1:0] smooth_angle;
        logic                       end_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic load_div;
        logic div_step;
        logic emit_done;
        logic clear_run;
    } t_cmd;

    typedef struct packed {
        logic want_result;
        logic run_last;
    } t_status;

    function automatic logic signed [SUM_W-1:0] sext_sample(
        input logic signed [SAMPLE_W-1:0] v
    );
        return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

endpackage

>>> rtl/cwts_ram.sv
// generic single write port ram with registered read
module cwts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/cwts_div_lane.sv
// one bit per cycle while i_step is high, signed sum by window count divider lane
module cwts_div_lane (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic                                i_step,
    input  logic signed [cwts_pkg::SUM_W-1:0]   i_dividend,
    input  logic        [cwts_pkg::CNT_W-1:0]   i_divisor,
    output logic signed [cwts_pkg::SAMPLE_W-1:0] o_quotient
);
    import cwts_pkg::*;

    logic [SUM_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_dvs;
    logic             r_neg;

    logic [SUM_W-1:0] dvd_u;
    logic [SUM_W-1:0] mag;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             fits;
    logic [SUM_W-1:0] signed_q;

    assign dvd_u = i_dividend;
    assign mag   = dvd_u[SUM_W-1] ? (~dvd_u + SUM_W'(1)) : dvd_u;
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        priority if (i_load) begin
            n_quo = mag;
            n_rem = '0;
        end else if (i_step) begin
            n_quo = {r_quo[SUM_W-2:0], fits};
            n_rem = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_load) begin
            r_dvs <= i_divisor;
            r_neg <= dvd_u[SUM_W-1];
        end
    end

    assign signed_q   = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quotient = signed_q[SAMPLE_W-1:0];

endmodule

>>> rtl/cwts_dp.sv
// datapath: running sums, sample store, window count and dividers
`include "centered_window_trajectory_smoother_top_defines.svh"
module cwts_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cwts_pkg::t_cmd       i_cmd,
    output cwts_pkg::t_status    o_status,
    input  cwts_pkg::t_in_item   i_in_item,
    output cwts_pkg::t_out_item  o_out_item
);
    import cwts_pkg::*;

    logic signed [SUM_W-1:0] r_sum_x, n_sum_x;
    logic signed [SUM_W-1:0] r_sum_y, n_sum_y;
    logic signed [SUM_W-1:0] r_sum_a, n_sum_a;
    logic [IDX_W-1:0]        r_seen, n_seen;
    logic [IDX_W-1:0]        r_nout, n_nout;
    logic                    r_last, n_last;
    logic                    r_eor;

    logic [IDX_W-1:0]        pending;
    logic [IDX_W-1:0]        old_idx;
    logic [CNT_W-1:0]        above;
    logic [CNT_W-1:0]        below;
    logic [CNT_W-1:0]        count;
    logic                    nout_past;
    logic [HIST_W-1:0]       wr_data;
    logic [HIST_W-1:0]       rd_data;
    logic signed [SAMPLE_W-1:0] old_x, old_y, old_a;

    assign pending   = r_seen - r_nout;
    assign old_idx   = r_nout - IDX_W'(RADIUS);
    assign nout_past = r_nout >= IDX_W'(RADIUS);
    assign above     = (pending > IDX_W'(RADIUS)) ? CNT_W'(RADIUS) : pending[CNT_W-1:0];
    assign below     = nout_past ? CNT_W'(RADIUS) : r_nout[CNT_W-1:0];
    assign count     = above + below;

    assign o_status.want_result = r_last ? (pending != '0) : (pending >= IDX_W'(RADIUS));
    assign o_status.run_last    = r_last;

    assign wr_data = {i_in_item.pos_x, i_in_item.pos_y, i_in_item.angle};
    assign old_x   = rd_data[3*SAMPLE_W-1:2*SAMPLE_W];
    assign old_y   = rd_data[2*SAMPLE_W-1:SAMPLE_W];
    assign old_a   = rd_data[SAMPLE_W-1:0];

    cwts_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load_sample),
        .i_wr_addr (r_seen[HIST_AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (old_idx[HIST_AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        n_sum_a = r_sum_a;
        n_seen  = r_seen;
        n_nout  = r_nout;
        n_last  = r_last;
        priority if (i_cmd.clear_run) begin
            n_sum_x = '0;
            n_sum_y = '0;
            n_sum_a = '0;
            n_seen  = '0;
            n_nout  = '0;
            n_last  = 1'b0;
        end else if (i_cmd.load_sample) begin
            n_sum_x = r_sum_x + sext_sample(i_in_item.pos_x);
            n_sum_y = r_sum_y + sext_sample(i_in_item.pos_y);
            n_sum_a = r_sum_a + sext_sample(i_in_item.angle);
            n_seen  = r_seen + IDX_W'(1);
            n_last  = i_in_item.final_sample;
        end else if (i_cmd.emit_done) begin
            if (nout_past) begin
                n_sum_x = r_sum_x - sext_sample(old_x);
                n_sum_y = r_sum_y - sext_sample(old_y);
                n_sum_a = r_sum_a - sext_sample(old_a);
            end
            n_nout = r_nout + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_a <= '0;
            r_seen  <= '0;
            r_nout  <= '0;
            r_last  <= 1'b0;
            r_eor   <= 1'b0;
        end else begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_sum_a <= n_sum_a;
            r_seen  <= n_seen;
            r_nout  <= n_nout;
            r_last  <= n_last;
            if (i_cmd.load_div) begin
                r_eor <= r_last && (pending == IDX_W'(1));
            end
        end
    end

    cwts_div_lane u_div_x (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_div),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_sum_x),
        .i_divisor  (count),
        .o_quotient (o_out_item.smooth_x)
    );

    cwts_div_lane u_div_y (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_div),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_sum_y),
        .i_divisor  (count),
        .o_quotient (o_out_item.smooth_y)
    );

    cwts_div_lane u_div_a (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_div),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_sum_a),
        .i_divisor  (count),
        .o_quotient (o_out_item.smooth_angle)
    );

    assign o_out_item.end_of_run = r_eor;

    `CWTS_ASSERT_IMP(a_count_nonzero, i_clk, i_rst_n, i_cmd.load_div, count != '0,
        "window count is zero at divider load")
    `CWTS_ASSERT_NXT(a_sample_pending, i_clk, i_rst_n, i_cmd.load_sample, r_seen != r_nout,
        "no pending result after a sample")
    `CWTS_ASSERT_NXT(a_last_drains, i_clk, i_rst_n, i_cmd.emit_done && r_eor,
        r_seen == r_nout, "results still pending after end of run")

endmodule

>>> rtl/cwts_ctrl.sv
// controller: sequencing of sample load, divide and result transaction
`include "centered_window_trajectory_smoother_top_defines.svh"
module cwts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  cwts_pkg::t_status i_status,
    output cwts_pkg::t_cmd    o_cmd
);
    import cwts_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_step  = '0;
                n_state = i_status.want_result ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_CHECK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load_sample = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.load_div    = (r_state == ST_CHECK) && i_status.want_result;
        o_cmd.clear_run   = (r_state == ST_CHECK) && !i_status.want_result
                            && i_status.run_last;
        o_cmd.div_step    = (r_state == ST_DIV);
        o_cmd.emit_done   = (r_state == ST_OUT) && !i_out_stall;
        o_out_valid       = (r_state == ST_OUT);
        o_in_stall        = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `CWTS_ASSERT_IMP(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall,
        "input open while a result is waiting")
    `CWTS_ASSERT_NXT(a_div_to_out, i_clk, i_rst_n, (r_state == ST_DIV) && (r_step == STEP_LAST),
        o_out_valid, "result not shown after last divide step")
    `CWTS_ASSERT_NXT(a_load_to_check, i_clk, i_rst_n, o_cmd.load_sample,
        (r_state == ST_CHECK) && o_in_stall, "sample transaction not followed by check")

endmodule

>>> rtl/centered_window_trajectory_smoother_top.sv
// top level of the centered window trajectory smoother
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (x, y, angle, final)
//  out     | output    | o_out_valid/ i_out_stall| o_out_item (means, end_of_run)
//
// a sample transaction is followed by a check state that decides on a result
// each result passes the check, the divide steps and an output state held while stalled
// a non-final sample gives at most one result
// a final one flushes every pending result, then a closing check clears the run
// synchronous active low reset clears sums and counters, no store clearing pass
// the input stalls whenever the block is busy, output stalls hold the result
module centered_window_trajectory_smoother_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cwts_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cwts_pkg::t_out_item o_out_item
);
    import cwts_pkg::*;

    t_cmd    cmd;
    t_status status;

    cwts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cwts_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

>>> verif/tb_centered_window_trajectory_smoother_top.sv
// self-checking testbench for the centered window trajectory smoother
module tb_centered_window_trajectory_smoother_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cwts_pkg::*;

    localparam int PHASE_ITEMS = 76;
    localparam int DRAIN_CYCLES = 100;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;

    // window state of the expected behavior
    logic signed [SAMPLE_W-1:0] hist_x [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_y [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_angle [HIST_DEPTH];
    logic signed [SUM_W-1:0] win_sum_x;
    logic signed [SUM_W-1:0] win_sum_y;
    logic signed [SUM_W-1:0] win_sum_angle;
    logic [IDX_W-1:0] seen_cnt;
    logic [IDX_W-1:0] next_mean_idx;
    t_out_item expected_means [$];

    centered_window_trajectory_smoother_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [SUM_W-1:0] widen(input logic signed [SAMPLE_W-1:0] v);
        return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    function automatic logic [SAMPLE_W-1:0] window_mean(input logic signed [SUM_W-1:0] sum,
                                                        input longint count);
        longint wide;
        wide = sum;
        return SAMPLE_W'(wide / count);
    endfunction

    function automatic void predict_means(input t_in_item item);
        logic [IDX_W-1:0] pending;
        logic [IDX_W-1:0] below;
        logic [IDX_W-1:0] old_idx;
        logic [HIST_AW-1:0] slot;
        longint count;
        t_out_item res;
        int k;
        slot = seen_cnt[HIST_AW-1:0];
        hist_x[slot] = item.pos_x;
        hist_y[slot] = item.pos_y;
        hist_angle[slot] = item.angle;
        win_sum_x = win_sum_x + widen(item.pos_x);
        win_sum_y = win_sum_y + widen(item.pos_y);
        win_sum_angle = win_sum_angle + widen(item.angle);
        seen_cnt = seen_cnt + 1;
        k = 0;
        while (k < 32) begin
            pending = seen_cnt - next_mean_idx;
            if (item.final_sample ? (pending == 0) : (pending < IDX_W'(RADIUS)))
                break;
            below = (next_mean_idx < IDX_W'(RADIUS)) ? next_mean_idx : IDX_W'(RADIUS);
            if (pending > IDX_W'(RADIUS))
                count = longint'(RADIUS) + longint'(below);
            else
                count = longint'(pending) + longint'(below);
            res.smooth_x = window_mean(win_sum_x, count);
            res.smooth_y = window_mean(win_sum_y, count);
            res.smooth_angle = window_mean(win_sum_angle, count);
            res.end_of_run = item.final_sample && (pending == 1);
            expected_means = {expected_means, res};
            k++;
            if (next_mean_idx >= IDX_W'(RADIUS)) begin
                old_idx = next_mean_idx - IDX_W'(RADIUS);
                win_sum_x = win_sum_x - widen(hist_x[old_idx[HIST_AW-1:0]]);
                win_sum_y = win_sum_y - widen(hist_y[old_idx[HIST_AW-1:0]]);
                win_sum_angle = win_sum_angle - widen(hist_angle[old_idx[HIST_AW-1:0]]);
            end
            next_mean_idx = next_mean_idx + 1;
        end
        if (item.final_sample) begin
            win_sum_x = '0;
            win_sum_y = '0;
            win_sum_angle = '0;
            seen_cnt = '0;
            next_mean_idx = '0;
        end
    endfunction

    function automatic t_in_item make_sample(input logic signed [SAMPLE_W-1:0] x,
                                             input logic signed [SAMPLE_W-1:0] y,
                                             input logic signed [SAMPLE_W-1:0] a,
                                             input logic last);
        t_in_item item;
        item.pos_x = x;
        item.pos_y = y;
        item.angle = a;
        item.final_sample = last;
        return item;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_coord(input int flavor);
        logic signed [SAMPLE_W-1:0] v;
        case (flavor)
            0: begin
                case ($urandom_range(4))
                    0: v = S_MAX;
                    1: v = S_MIN;
                    2: v = -1;
                    3: v = 0;
                    default: v = 1;
                endcase
            end
            1: v = $signed($urandom_range(4000)) - 2000;
            2: v = ($signed($urandom_range(2000)) - 1000) <<< 16;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_sample(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_means(item);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_means.size() != 0);
    endtask

    task automatic run_random_phase(input int n_items);
        int sent;
        int len;
        int pick;
        int flavor;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 10)
                len = 1;
            else if (pick < 22)
                len = $urandom_range(2, 6);
            else if (pick < 85)
                len = $urandom_range(25, 70);
            else
                len = $urandom_range(71, 130);
            if (len > n_items - sent)
                len = n_items - sent;
            flavor = $urandom_range(3);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0)
                    flavor = $urandom_range(3);
                send_sample(make_sample(random_coord(flavor), random_coord(flavor),
                                        random_coord(flavor), i == len - 1));
            end
            sent += len;
        end
        wait_for_results();
    endtask

    task automatic test_edge_sequences();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // single-sample runs at both extremes
        send_sample(make_sample(S_MAX, S_MIN, -1, 1'b1));
        send_sample(make_sample(S_MIN, S_MAX, 0, 1'b1));
        // odd negative sum truncates toward zero
        send_sample(make_sample(-7, 7, -1, 1'b0));
        send_sample(make_sample(0, 0, 0, 1'b1));
        send_sample(make_sample(S_MAX, S_MIN, 32'sh00010000, 1'b0));
        send_sample(make_sample(S_MIN, S_MAX, -32'sh00010000, 1'b0));
        send_sample(make_sample(-1, 1, S_MAX, 1'b1));
        for (int i = 0; i < 5; i++)
            send_sample(make_sample(S_MAX, S_MAX, S_MAX, i == 4));
        for (int i = 0; i < 5; i++)
            send_sample(make_sample(S_MIN, S_MIN, S_MIN, i == 4));
        wait_for_results();
    endtask

    task automatic test_streaming_no_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random_phase(PHASE_ITEMS);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 88;
        recv_stall_pct = 0;
        run_random_phase(PHASE_ITEMS);
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 88;
        run_random_phase(PHASE_ITEMS);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 16;
        recv_stall_pct = 16;
        run_random_phase(PHASE_ITEMS);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_means
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_means.size() == 0) begin
                $error("unexpected result transaction: %h", o_out_item);
                error_count++;
            end else begin
                want = expected_means.pop_front();
                if (o_out_item.smooth_x !== want.smooth_x) begin
                    $error("smooth_x expected %0d actual %0d", want.smooth_x,
                           o_out_item.smooth_x);
                    error_count++;
                end
                if (o_out_item.smooth_y !== want.smooth_y) begin
                    $error("smooth_y expected %0d actual %0d", want.smooth_y,
                           o_out_item.smooth_y);
                    error_count++;
                end
                if (o_out_item.smooth_angle !== want.smooth_angle) begin
                    $error("smooth_angle expected %0d actual %0d", want.smooth_angle,
                           o_out_item.smooth_angle);
                    error_count++;
                end
                if (o_out_item.end_of_run !== want.end_of_run) begin
                    $error("end_of_run expected %0b actual %0b", want.end_of_run,
                           o_out_item.end_of_run);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("tb_centered_window_trajectory_smoother_top NOT OK");
        $finish;
    end

    initial begin
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        win_sum_x = '0;
        win_sum_y = '0;
        win_sum_angle = '0;
        seen_cnt = '0;
        next_mean_idx = '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
            hist_angle[i] = '0;
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_out_stall <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_sequences();
        test_streaming_no_idle();
        test_sender_gaps();
        test_receiver_backpressure();
        test_both_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_means.size() == 0)
            $display("tb_centered_window_trajectory_smoother_top OK");
        else
            $display("tb_centered_window_trajectory_smoother_top NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cwts_pkg.sv
rtl/cwts_ram.sv
rtl/cwts_div_lane.sv
rtl/cwts_dp.sv
rtl/cwts_ctrl.sv
rtl/centered_window_trajectory_smoother_top.sv
verif/tb_centered_window_trajectory_smoother_top.sv
